// File: src/berf_pkg.sv
`default_nettype none

package berf_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int EVENT_WIDTH_DEF = 64;

    localparam int WORD_W = 64;
    localparam int SEQ_W  = 32;
    localparam int PEAK_W = 11;

    // Request codes as they arrive on the input channel.
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_POP,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef enum logic {
        BK_RUN,
        BK_POP_WAIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] event_word;
    } req_item_t;

    typedef struct packed {
        logic              accepted;
        logic [WORD_W-1:0] event_data;
        logic [SEQ_W-1:0]  sequence_number;
        logic [SEQ_W-1:0]  drop_total;
        logic [PEAK_W-1:0] peak_occupancy;
    } rsp_item_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [WORD_W-1:0] event_word;
    } cmd_t;

endpackage

`default_nettype wire

// File: src/berf_front.sv
`default_nettype none

module berf_front #(
    parameter int EVENT_WIDTH = berf_pkg::EVENT_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire berf_pkg::req_item_t req,
    output logic                     cmd_valid,
    input  wire logic                cmd_ready,
    output berf_pkg::cmd_t           cmd
);
    import berf_pkg::*;

    cmd_t       q_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cmd_t       cmd_in;
    logic       push_q;
    logic       pop_q;

    // Decode the request and keep only the event bits the ring stores.
    always_comb
    begin
        cmd_in.event_word = WORD_W'(req.event_word[EVENT_WIDTH-1:0]);
        unique case (req.req_type)
            REQ_PUSH:  cmd_in.kind = CMD_PUSH;
            REQ_POP:   cmd_in.kind = CMD_POP;
            REQ_CLEAR: cmd_in.kind = CMD_CLEAR;
            default:   cmd_in.kind = CMD_NOP;
        endcase
    end

    assign req_ready = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push_q    = req_valid && req_ready;
    assign pop_q     = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push_q ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_q ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_q} - {1'b0, pop_q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// File: src/berf_back.sv
`default_nettype none

module berf_back #(
    parameter int DEPTH       = berf_pkg::DEPTH_DEF,
    parameter int EVENT_WIDTH = berf_pkg::EVENT_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire berf_pkg::cmd_t      cmd,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output berf_pkg::rsp_item_t      rsp
);
    import berf_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH) + 1;

    logic [EVENT_WIDTH-1:0] mem [0:DEPTH-1];
    logic [EVENT_WIDTH-1:0] rd_data_reg;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [SEQ_W-1:0]  wc_reg;
    logic [SEQ_W-1:0]  wc_next;
    logic [SEQ_W-1:0]  rc_reg;
    logic [SEQ_W-1:0]  rc_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [OCC_W-1:0]  hw_reg;
    logic [OCC_W-1:0]  hw_next;
    logic [SEQ_W-1:0]  drop_reg;
    logic [SEQ_W-1:0]  drop_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_item_t         rsp_reg;
    rsp_item_t         rsp_next;

    logic              can_issue;
    logic              take;
    logic              full;
    logic              empty;
    logic [OCC_W-1:0]  occ_inc;
    logic              rsp_load;
    logic              mem_we;
    logic              mem_re;

    assign can_issue = !rsp_valid_reg || rsp_ready;
    assign full      = (occ_reg == OCC_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign occ_inc   = occ_reg + OCC_W'(1);
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (take && cmd.kind == CMD_POP && !empty)
                begin
                    state_next = BK_POP_WAIT;
                end
            end
            BK_POP_WAIT:
            begin
                state_next = BK_RUN;
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        rsp_load  = 1'b0;
        wc_next   = wc_reg;
        rc_next   = rc_reg;
        occ_next  = occ_reg;
        hw_next   = hw_reg;
        drop_next = drop_reg;
        rsp_next  = rsp_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                cmd_ready = can_issue;
                if (take)
                begin
                    rsp_load                 = 1'b1;
                    rsp_next.accepted        = 1'b0;
                    rsp_next.event_data      = '0;
                    rsp_next.sequence_number = '0;
                    unique case (cmd.kind)
                        CMD_PUSH:
                        begin
                            if (full)
                            begin
                                if (drop_reg != '1)
                                begin
                                    drop_next = drop_reg + SEQ_W'(1);
                                end
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                wc_next  = wc_reg + SEQ_W'(1);
                                occ_next = occ_inc;
                                if (occ_inc > hw_reg)
                                begin
                                    hw_next = occ_inc;
                                end
                                rsp_next.accepted        = 1'b1;
                                rsp_next.sequence_number = wc_next;
                            end
                        end
                        CMD_POP:
                        begin
                            // The data comes back from the registered memory read port in the following cycle,
                            // so the result is built in the wait state.
                            if (!empty)
                            begin
                                mem_re   = 1'b1;
                                rsp_load = 1'b0;
                                rc_next  = rc_reg + SEQ_W'(1);
                                occ_next = occ_reg - OCC_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            wc_next           = '0;
                            rc_next           = '0;
                            occ_next          = '0;
                            hw_next           = '0;
                            drop_next         = '0;
                            rsp_next.accepted = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.drop_total     = drop_next;
                    rsp_next.peak_occupancy = PEAK_W'(hw_next);
                end
            end
            BK_POP_WAIT:
            begin
                rsp_load                 = 1'b1;
                rsp_next.accepted        = 1'b1;
                rsp_next.event_data      = WORD_W'(rd_data_reg);
                rsp_next.sequence_number = rc_reg;
                rsp_next.drop_total      = drop_reg;
                rsp_next.peak_occupancy  = PEAK_W'(hw_reg);
            end
            default:
            begin
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            wc_reg        <= '0;
            rc_reg        <= '0;
            occ_reg       <= '0;
            hw_reg        <= '0;
            drop_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wc_reg        <= wc_next;
            rc_reg        <= rc_next;
            occ_reg       <= occ_next;
            hw_reg        <= hw_next;
            drop_reg      <= drop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wc_reg[AW-1:0]] <= cmd.event_word[EVENT_WIDTH-1:0];
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rc_reg[AW-1:0]];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: src/bounded_event_ring_fifo.sv
`default_nettype none

// Event ring of DEPTH slots with a drop counter and a high-water mark. Each request
// (push, pop, clear) gives exactly one response. A successful pop, unlike a push, a clear,
// a failed pop or an unused code, also passes through a wait state in the execution
// stage, because the slot memory has a registered read port. A two-entry command queue
// sits between the request decoder and the execution stage, and the response is held in
// an output register, so the queue can take requests while a response waits.
// The slot memory needs no initialization after reset.
module bounded_event_ring_fifo #(
    parameter int DEPTH       = berf_pkg::DEPTH_DEF,
    parameter int EVENT_WIDTH = berf_pkg::EVENT_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire berf_pkg::req_item_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output berf_pkg::rsp_item_t      rsp
);
    import berf_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    berf_front #(
        .EVENT_WIDTH(EVENT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    berf_back #(
        .DEPTH       (DEPTH),
        .EVENT_WIDTH (EVENT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef ASSERT_OFF
    a_no_issue_into_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |-> (!rsp_valid || rsp_ready)
    ) else $error("command issued while the response register was stalled");

    a_queue_full_has_cmd: assert property (
        @(posedge clk) disable iff (!rst_n)
        !req_ready |-> cmd_valid
    ) else $error("request channel stalled with an empty command queue");

    a_issue_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (rsp_valid || !cmd_ready)
    ) else $error("issued command produced no response and no pop wait");
`endif

endmodule

`default_nettype wire

// File: verif/bounded_event_ring_fifo_tb.sv
`default_nettype none

module bounded_event_ring_fifo_tb;

    import berf_pkg::*;

    localparam int RING_SLOTS = DEPTH_DEF;
    localparam int SLOT_BITS  = $clog2(RING_SLOTS);
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 20;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    // Shadow copy of the ring and its statistics.
    logic [WORD_W-1:0] ring_words [RING_SLOTS];
    logic [SEQ_W-1:0]  push_total;
    logic [SEQ_W-1:0]  pop_total;
    logic [SEQ_W-1:0]  dropped_pushes;
    logic [SEQ_W-1:0]  peak_fill;

    req_item_t request_stream [$];
    rsp_item_t awaited_responses [$];

    int error_count    = 0;
    int responses_seen = 0;
    int send_gap       = 0;
    int send_calm      = 0;
    int recv_gap       = 0;
    int recv_calm      = 0;
    logic hold_off     = 1'b0;
    int hold_left      = 0;
    int holds_done     = 0;

    bounded_event_ring_fifo u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    function automatic rsp_item_t ring_outcome(req_item_t r);
        rsp_item_t o;
        logic [SEQ_W-1:0] fill;
        o = '0;
        fill = push_total - pop_total;
        case (r.req_type)
            REQ_PUSH:
            begin
                if (fill >= RING_SLOTS)
                begin
                    if (dropped_pushes != '1)
                        dropped_pushes++;
                end
                else
                begin
                    ring_words[push_total[SLOT_BITS-1:0]] = r.event_word;
                    push_total++;
                    o.accepted = 1'b1;
                    o.sequence_number = push_total;
                    if (fill + 1 > peak_fill)
                        peak_fill = fill + 1;
                end
            end
            REQ_POP:
            begin
                if (fill != 0)
                begin
                    o.event_data = ring_words[pop_total[SLOT_BITS-1:0]];
                    pop_total++;
                    o.accepted = 1'b1;
                    o.sequence_number = pop_total;
                end
            end
            REQ_CLEAR:
            begin
                push_total     = '0;
                pop_total      = '0;
                dropped_pushes = '0;
                peak_fill      = '0;
                o.accepted     = 1'b1;
            end
            default:
            begin
            end
        endcase
        o.drop_total     = dropped_pushes;
        o.peak_occupancy = peak_fill[PEAK_W-1:0];
        return o;
    endfunction

    // Mostly short gaps, now and then a long one, and occasional runs with none.
    function automatic int pick_gap(inout int calm_left);
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic req_item_t make_req(logic [1:0] kind, logic [WORD_W-1:0] word);
        req_item_t r;
        r.req_type   = kind;
        r.event_word = word;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Request driver: each accepted transaction is run through the shadow ring.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                awaited_responses.push_back(ring_outcome(req));
            if (!(req_valid && !req_ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (request_stream.size() != 0)
                begin
                    req       <= request_stream.pop_front();
                    req_valid <= 1'b1;
                    send_gap  = pick_gap(send_calm);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    $display("%0t: unexpected response: expected none, actual %h", $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    check_field("accepted", want.accepted, rsp.accepted);
                    check_field("event_data", want.event_data, rsp.event_data);
                    check_field("sequence_number", want.sequence_number, rsp.sequence_number);
                    check_field("drop_total", want.drop_total, rsp.drop_total);
                    check_field("peak_occupancy", want.peak_occupancy, rsp.peak_occupancy);
                end
                responses_seen <= responses_seen + 1;
                recv_gap = pick_gap(recv_calm);
            end
            else if (recv_gap > 0)
                recv_gap--;
            rsp_ready <= (recv_gap == 0) && !hold_off;
        end
    end

    // Long receiver hold-offs so that the internal queue fills and the input stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off   <= 1'b0;
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_off)
        begin
            if (hold_left == 0)
            begin
                hold_off   <= 1'b0;
                holds_done <= holds_done + 1;
            end
            else
                hold_left <= hold_left - 1;
        end
        else if (holds_done < 2 && responses_seen >= 150 + holds_done * 900)
        begin
            hold_off  <= 1'b1;
            hold_left <= 300;
        end
    end

    initial
    begin
        int mixed;
        int seg_len;
        int push_odds;
        int sel;
        bit filled;

        push_total     = '0;
        pop_total      = '0;
        dropped_pushes = '0;
        peak_fill      = '0;

        // Directed: empty ring, unused code, extreme payloads, clear with data held.
        request_stream.push_back(make_req(REQ_POP, '0));
        request_stream.push_back(make_req(REQ_UNUSED, '1));
        request_stream.push_back(make_req(REQ_PUSH, '0));
        request_stream.push_back(make_req(REQ_PUSH, '1));
        request_stream.push_back(make_req(REQ_PUSH, {16{4'hA}}));
        request_stream.push_back(make_req(REQ_PUSH, {16{4'h5}}));
        request_stream.push_back(make_req(REQ_UNUSED, random_word()));
        request_stream.push_back(make_req(REQ_POP, random_word()));
        request_stream.push_back(make_req(REQ_POP, '0));
        request_stream.push_back(make_req(REQ_CLEAR, '1));
        request_stream.push_back(make_req(REQ_POP, '0));
        request_stream.push_back(make_req(REQ_PUSH, random_word()));
        request_stream.push_back(make_req(REQ_PUSH, random_word()));
        request_stream.push_back(make_req(REQ_CLEAR, random_word()));
        request_stream.push_back(make_req(REQ_POP, '1));
        request_stream.push_back(make_req(REQ_PUSH, 64'h8000_0000_0000_0001));
        request_stream.push_back(make_req(REQ_POP, '0));
        request_stream.push_back(make_req(REQ_POP, '0));
        request_stream.push_back(make_req(REQ_UNUSED, '0));

        // Random: runs of pushes and pops with a varying bias, a burst that
        // overfills the ring midway, and some clears and unused codes.
        mixed  = 0;
        filled = 1'b0;
        while (mixed < 60)
        begin
            if (!filled && mixed >= 30)
            begin
                repeat (RING_SLOTS + $urandom_range(4, 16))
                    request_stream.push_back(make_req(REQ_PUSH, random_word()));
                filled = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                seg_len   = $urandom_range(4, 40);
                push_odds = $urandom_range(20, 80);
                repeat (seg_len)
                    request_stream.push_back(make_req(
                        ($urandom_range(1, 100) <= push_odds) ? REQ_PUSH : REQ_POP,
                        random_word()));
                mixed += seg_len;
            end
            else if (sel < 88)
            begin
                seg_len = $urandom_range(5, 30);
                repeat (seg_len)
                    request_stream.push_back(make_req(REQ_POP, random_word()));
                mixed += seg_len;
            end
            else if (sel < 95)
            begin
                repeat ($urandom_range(1, 3))
                    request_stream.push_back(make_req(REQ_UNUSED, random_word()));
            end
            else
            begin
                request_stream.push_back(make_req(REQ_CLEAR, random_word()));
                mixed++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (request_stream.size() != 0 || req_valid || awaited_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (awaited_responses.size() != 0)
        begin
            $display("%0t: missing responses: expected %0d more, actual 0", $time,
                     awaited_responses.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/berf_pkg.sv
src/berf_front.sv
src/berf_back.sv
src/bounded_event_ring_fifo.sv
verif/bounded_event_ring_fifo_tb.sv
